// ===== src/rfm_pkg.sv =====
// ----------------------------------------------------------------------------
// rfm_pkg: shared types and constants of the floor texel mapper
// Field widths, configuration register indexes and the payload that travels
// down the pipeline next to the divider.
// ----------------------------------------------------------------------------
package rfm_pkg;

  // Screen coordinates and config.
  localparam int unsigned RowW    = 11;
  localparam int unsigned TexSzW  = 9;
  localparam int unsigned CfgW    = 11;
  localparam int unsigned CfgIdxW = 2;

  // Fixed-point widths.
  localparam int unsigned CellW  = 6;
  localparam int unsigned FracW  = 16;
  localparam int unsigned PosW   = 22;
  localparam int unsigned CoordW = 23;   // floor point up to 64.0 in Q7.16
  localparam int unsigned DistW  = 24;
  localparam int unsigned DenW   = RowW + DistW;        // (2*row - H) * wall_dist
  localparam int unsigned NumW   = RowW + 2 * FracW;    // H << 32
  localparam int unsigned TrialW = DenW + FracW;        // widest shifted divisor
  localparam int unsigned WgtW   = FracW + 1;           // weight in [0, 1.0]
  localparam int unsigned TexW   = 8;

  localparam int unsigned MapSizeDef = 64;

  // Reset values of the configuration registers.
  localparam logic [RowW-1:0]   ScreenHeightRst = 11'd480;
  localparam logic [TexSzW-1:0] TexSizeRst      = 9'd64;
  localparam logic [TexSzW-1:0] TexSizeMax      = 9'd256;

  typedef enum logic [CfgIdxW-1:0] {
    CfgScreenHeight  = 2'd0,
    CfgTextureWidth  = 2'd1,
    CfgTextureHeight = 2'd2
  } cfg_idx_e;

  // Pixel data that rides along with the weight computation.
  typedef struct packed {
    logic [RowW-1:0]   column;
    logic [RowW-1:0]   row;
    logic [RowW-1:0]   ceil_row;
    logic [CoordW-1:0] fx;
    logic [CoordW-1:0] fy;
    logic [PosW-1:0]   px;
    logic [PosW-1:0]   py;
  } pixel_t;

  // Texture sizes above 256 behave as 256.
  function automatic logic [TexSzW-1:0] clamp_size(input logic [TexSzW-1:0] s);
    return (s > TexSizeMax) ? TexSizeMax : s;
  endfunction

endpackage

// ===== src/raycast_floor_texel_mapper.sv =====
// ----------------------------------------------------------------------------
// raycast_floor_texel_mapper: floor and ceiling texel coordinates per pixel
// Maps one screen pixel below a wall slice to the texel of the floor point
// it shows, interpolated between the wall base and the player position.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on every rising edge with start high; busy stays low,
//   so one pixel can be issued in every clock cycle.
//   Pixels that are not shaded (at or above the horizon, not below the wall
//   end, or outside the screen) produce no result and simply drop out.
//   A shaded pixel gives one result, shown for one cycle with
//   result_valid_o high. The receiver cannot stall, so the
//   pipeline never holds and results leave in request order.
//   The pipeline has the entry, divisor multiply and divider load stages,
//   the weight divider with sixteen restoring steps, one quotient bit per
//   stage, and then the interpolation product, sum and texel stages.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once;
//   the user makes them while no request is in flight; the block does not enforce it.
//   Reset clears the stage valid bits and loads screen height 480 and a
//   64 by 64 texture.
// ----------------------------------------------------------------------------
module raycast_floor_texel_mapper #(
  parameter int unsigned MapSize = rfm_pkg::MapSizeDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cfg_we_i,
  input  logic [rfm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rfm_pkg::CfgW-1:0]    cfg_data_i,
  input  logic [rfm_pkg::RowW-1:0]    row_i,
  input  logic [rfm_pkg::RowW-1:0]    column_i,
  input  logic signed [rfm_pkg::RowW:0] wall_end_row_i,
  input  logic                        hit_side_i,
  input  logic                        ray_x_positive_i,
  input  logic                        ray_y_positive_i,
  input  logic [rfm_pkg::CellW-1:0]   map_x_i,
  input  logic [rfm_pkg::CellW-1:0]   map_y_i,
  input  logic [rfm_pkg::FracW-1:0]   wall_frac_i,
  input  logic [rfm_pkg::DistW-1:0]   wall_dist_i,
  input  logic [rfm_pkg::PosW-1:0]    pos_x_i,
  input  logic [rfm_pkg::PosW-1:0]    pos_y_i,
  output logic                        result_valid_o,
  output logic [rfm_pkg::RowW-1:0]    pixel_column_o,
  output logic [rfm_pkg::RowW-1:0]    floor_row_o,
  output logic [rfm_pkg::RowW-1:0]    ceiling_row_o,
  output logic [rfm_pkg::TexW-1:0]    texel_u_o,
  output logic [rfm_pkg::TexW-1:0]    texel_v_o
);
  import rfm_pkg::*;

  localparam int unsigned DivSteps = FracW;

  // Configuration registers.
  logic [RowW-1:0]   screen_height_q;
  logic [TexSzW-1:0] texture_width_q, texture_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_height_q  <= ScreenHeightRst;
      texture_width_q  <= TexSizeRst;
      texture_height_q <= TexSizeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgScreenHeight:  screen_height_q  <= cfg_data_i;
        CfgTextureWidth:  texture_width_q  <= cfg_data_i[TexSzW-1:0];
        CfgTextureHeight: texture_height_q <= cfg_data_i[TexSzW-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Entry stage: shading test, wall base point and row offset.
  logic              shade_d;
  logic [CellW-1:0]  mx, my;
  logic [CoordW-1:0] mx_c, my_c, mx1_c, my1_c;
  pixel_t            pix_d;
  logic [RowW-1:0]   diff_d;

  always_comb begin
    shade_d = start
            && ($signed({1'b0, row_i}) > wall_end_row_i)
            && (row_i < screen_height_q)
            && ({row_i, 1'b0} > {1'b0, screen_height_q});
    mx = (int'(map_x_i) >= int'(MapSize)) ? CellW'(MapSize - 1) : map_x_i;
    my = (int'(map_y_i) >= int'(MapSize)) ? CellW'(MapSize - 1) : map_y_i;
    mx_c  = {1'b0, mx, {FracW{1'b0}}};
    my_c  = {1'b0, my, {FracW{1'b0}}};
    mx1_c = {(CellW + 1)'(mx) + (CellW + 1)'(1), {FracW{1'b0}}};
    my1_c = {(CellW + 1)'(my) + (CellW + 1)'(1), {FracW{1'b0}}};
    pix_d.column   = column_i;
    pix_d.row      = row_i;
    pix_d.ceil_row = screen_height_q - row_i;
    pix_d.px       = pos_x_i;
    pix_d.py       = pos_y_i;
    if (!hit_side_i) begin
      pix_d.fx = ray_x_positive_i ? mx_c : mx1_c;
      pix_d.fy = my_c + CoordW'(wall_frac_i);
    end else begin
      pix_d.fx = mx_c + CoordW'(wall_frac_i);
      pix_d.fy = ray_y_positive_i ? my_c : my1_c;
    end
    diff_d = RowW'({row_i, 1'b0} - {1'b0, screen_height_q});
  end

  logic             v0_q;
  pixel_t           pix0_q;
  logic [RowW-1:0]  diff0_q;
  logic [DistW-1:0] dist0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else         v0_q <= shade_d;
  end

  always_ff @(posedge clk_i) begin
    pix0_q  <= pix_d;
    diff0_q <= diff_d;
    dist0_q <= wall_dist_i;
  end

  // Divisor: (2*row - H) * wall_dist.
  logic            v1_q;
  pixel_t          pix1_q;
  logic [DenW-1:0] den1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= v0_q;
  end

  always_ff @(posedge clk_i) begin
    pix1_q <= pix0_q;
    den1_q <= DenW'(diff0_q) * DenW'(dist0_q);
  end

  // Divider stage arrays; index 0 holds the loaded dividend.
  logic              dv_v_q   [DivSteps+1];
  pixel_t            dv_pix_q [DivSteps+1];
  logic [DenW-1:0]   dv_den_q [DivSteps+1];
  logic [NumW-1:0]   dv_rem_q [DivSteps+1];
  logic [FracW-1:0]  dv_quo_q [DivSteps+1];
  logic              dv_sat_q [DivSteps+1];

  // Load: weight saturates when H << 16 reaches the divisor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_v_q[0] <= 1'b0;
    else         dv_v_q[0] <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    dv_pix_q[0] <= pix1_q;
    dv_den_q[0] <= den1_q;
    dv_rem_q[0] <= {screen_height_q, {(2 * FracW){1'b0}}};
    dv_quo_q[0] <= '0;
    dv_sat_q[0] <= DenW'({screen_height_q, {FracW{1'b0}}}) >= den1_q;
  end

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    localparam int unsigned Sh = DivSteps - 1 - k;
    logic [TrialW-1:0] trial;
    logic              take;

    assign trial = TrialW'(dv_den_q[k]) << Sh;
    assign take  = TrialW'(dv_rem_q[k]) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[k+1] <= 1'b0;
      else         dv_v_q[k+1] <= dv_v_q[k];
    end

    always_ff @(posedge clk_i) begin
      dv_pix_q[k+1] <= dv_pix_q[k];
      dv_den_q[k+1] <= dv_den_q[k];
      dv_sat_q[k+1] <= dv_sat_q[k];
      dv_rem_q[k+1] <= take ? NumW'(TrialW'(dv_rem_q[k]) - trial) : dv_rem_q[k];
      dv_quo_q[k+1] <= dv_quo_q[k] | (take ? FracW'(1) << Sh : '0);
    end
  end

  // Interpolation products.
  logic [WgtW-1:0] wgt, wgt_inv;

  assign wgt     = dv_sat_q[DivSteps] ? {1'b1, {FracW{1'b0}}} : {1'b0, dv_quo_q[DivSteps]};
  assign wgt_inv = {1'b1, {FracW{1'b0}}} - wgt;

  localparam int unsigned ProdW = WgtW + CoordW;

  logic             vm_q;
  pixel_t           pixm_q;
  logic [ProdW-1:0] wfx_q, wfy_q, wpx_q, wpy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vm_q <= 1'b0;
    else         vm_q <= dv_v_q[DivSteps];
  end

  always_ff @(posedge clk_i) begin
    pixm_q <= dv_pix_q[DivSteps];
    wfx_q  <= ProdW'(wgt) * ProdW'(dv_pix_q[DivSteps].fx);
    wfy_q  <= ProdW'(wgt) * ProdW'(dv_pix_q[DivSteps].fy);
    wpx_q  <= ProdW'(wgt_inv) * ProdW'(dv_pix_q[DivSteps].px);
    wpy_q  <= ProdW'(wgt_inv) * ProdW'(dv_pix_q[DivSteps].py);
  end

  // Sum and keep the fractional part of the floor coordinate.
  logic [ProdW-1:0] sum_x, sum_y;
  logic             va_q;
  pixel_t           pixa_q;
  logic [FracW-1:0] frx_q, fry_q;

  assign sum_x = wfx_q + wpx_q;
  assign sum_y = wfy_q + wpy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else         va_q <= vm_q;
  end

  always_ff @(posedge clk_i) begin
    pixa_q <= pixm_q;
    frx_q  <= sum_x[2*FracW-1:FracW];
    fry_q  <= sum_y[2*FracW-1:FracW];
  end

  // Texel scaling and output register.
  localparam int unsigned TexProdW = FracW + TexSzW;

  logic [TexProdW-1:0] tu_prod, tv_prod;

  assign tu_prod = TexProdW'(frx_q) * TexProdW'(clamp_size(texture_width_q));
  assign tv_prod = TexProdW'(fry_q) * TexProdW'(clamp_size(texture_height_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) result_valid_o <= 1'b0;
    else         result_valid_o <= va_q;
  end

  always_ff @(posedge clk_i) begin
    pixel_column_o <= pixa_q.column;
    floor_row_o    <= pixa_q.row;
    ceiling_row_o  <= pixa_q.ceil_row;
    texel_u_o      <= tu_prod[FracW+TexW-1:FracW];
    texel_v_o      <= tv_prod[FracW+TexW-1:FracW];
  end

`ifndef SYNTHESIS
  // The two rows of a result add up to the screen height.
  a_rows_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> RowW'(floor_row_o + ceiling_row_o) == screen_height_q)
    else $error("floor and ceiling rows do not mirror");

  // Texel coordinates stay inside the texture.
  a_texel_u_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && texture_width_q != '0)
      |-> {1'b0, texel_u_o} < clamp_size(texture_width_q))
    else $error("texel_u outside texture width");

  a_texel_v_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && texture_height_q != '0)
      |-> {1'b0, texel_v_o} < clamp_size(texture_height_q))
    else $error("texel_v outside texture height");

  // An unsaturated quotient leaves a remainder below the divisor.
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_v_q[DivSteps] && !dv_sat_q[DivSteps])
      |-> TrialW'(dv_rem_q[DivSteps]) < TrialW'(dv_den_q[DivSteps]))
    else $error("divider remainder not reduced");
`endif

endmodule
